[rtl/ddo_pkg.sv]
package ddo_pkg;

	// register map (word index of the apb address)
	localparam int CFG_ADDR_W = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_USE_IMU   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_USE_ROT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WHEEL_DIA = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TRACK     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TRACK_EN  = 3'd4;

	localparam int DEF_CORDIC_STEPS = 16;
	localparam int DEF_FRAC_BITS = 16;

	// datapath widths
	localparam int DATA_W = 32;
	localparam int MAG_W = 33;
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 32;
	localparam int DIG_W = 16;
	localparam int MUL_PARTS = 3;
	localparam int PROD_W = 64;
	localparam int TRAV_W = 36;
	localparam int DTH_W = 45;
	localparam int DIV_W = 44;
	localparam int DREM_W = 20;
	localparam int RED_W = 21;
	localparam int CNT_W = 6;
	localparam int SUM_W = 66;

	localparam logic [MUL_B_W-1:0] DEG2RAD_Q32 = 32'd74961321;
	localparam logic [DREM_W-1:0] TWO_PI_Q16 = 20'd411775;
	localparam logic [DREM_W-1:0] FOUR_PI_Q16 = 20'd823550;
	localparam logic signed [RED_W-1:0] TWO_PI_S = 21'sd411775;
	localparam logic signed [RED_W-1:0] PI_Q16 = 21'sd205887;
	localparam logic signed [RED_W-1:0] HALF_PI_Q16 = 21'sd102944;
	localparam logic [30:0] GAIN_Q30 = 31'd652032874;

	// angle reduction: quotient estimate is ((a >> RECIP_PRE) * RECIP_TWO_PI) >> RECIP_SH,
	// with RECIP_TWO_PI = floor(2^42 / TWO_PI_Q16); the estimate is at most two low
	localparam logic [MUL_B_W-1:0] RECIP_TWO_PI = 32'd10680703;
	localparam int RECIP_PRE = 8;
	localparam int RECIP_SH = 34;

	typedef enum logic [4:0] {
		ST_IDLE, ST_START, ST_R1, ST_R2, ST_L1, ST_L2, ST_HDG, ST_IMU, ST_DTH,
		ST_ANG, ST_MOD, ST_MQD, ST_MFIX, ST_CGO, ST_COR, ST_MX, ST_MY, ST_FIN, ST_OUT
	} ddo_state_t;

	// cordic arctangent table, q30 radians
	function automatic logic [30:0] atan_q30(input logic [4:0] idx);
		case (idx)
			5'd0: return 31'd843314857;
			5'd1: return 31'd497837829;
			5'd2: return 31'd263043837;
			5'd3: return 31'd133525159;
			5'd4: return 31'd67021687;
			5'd5: return 31'd33543516;
			5'd6: return 31'd16775851;
			5'd7: return 31'd8388437;
			5'd8: return 31'd4194283;
			5'd9: return 31'd2097149;
			5'd10: return 31'd1048576;
			5'd11: return 31'd524288;
			5'd12: return 31'd262144;
			5'd13: return 31'd131072;
			5'd14: return 31'd65536;
			5'd15: return 31'd32768;
			5'd16: return 31'd16384;
			5'd17: return 31'd8192;
			5'd18: return 31'd4096;
			5'd19: return 31'd2048;
			5'd20: return 31'd1024;
			5'd21: return 31'd512;
			5'd22: return 31'd256;
			5'd23: return 31'd128;
			5'd24: return 31'd64;
			5'd25: return 31'd32;
			5'd26: return 31'd16;
			5'd27: return 31'd8;
			5'd28: return 31'd4;
			5'd29: return 31'd2;
			default: return 31'd0;
		endcase
	endfunction

	// clamp a wide sum to signed 32 bits
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] max_v;
		logic signed [SUM_W-1:0] min_v;
		max_v = 66'sd2147483647;
		min_v = -66'sd2147483648;
		if (v > max_v) return 32'sh7FFFFFFF;
		if (v < min_v) return 32'sh80000000;
		return v[DATA_W-1:0];
	endfunction

endpackage

[rtl/differential_drive_odometry.sv]
// Differential-drive odometry, midpoint-arc dead reckoning.
// Input channel (in_valid/in_ready) carries one sample tick: rotation sensor,
// motor encoder and imu readings. Output channel (out_valid/out_ready) carries
// the pose after that tick, one transfer per input transfer.
// Configuration is an apb-style port, word registers at 0x0..0x10; the user
// must write them only while the block is idle, which the block itself does
// not enforce; pready is tied high. When the pose is held (first tick or
// tracking off) the sequencer records the readings and goes straight to the
// output; with tracking on it runs four shared multiplies for wheel travel,
// a 44-bit restoring divide for wheel heading (skipped at zero track width)
// or a multiply for imu heading, midpoint angle reduction by reciprocal
// multiply, the cordic and two more multiplies. One item at a time; the
// multiplier is a shared 16x32 unit, the divider gives one quotient bit per
// cycle.
// A finished result sits in the output register; a new input is taken while
// it waits, but the next result is held back until out_ready takes the first.
// Reset clears pose, previous readings and registers; the first tick only
// records readings.
module differential_drive_odometry import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [DATA_W-1:0] rot_right,
	input  logic signed [DATA_W-1:0] rot_left,
	input  logic signed [DATA_W-1:0] motor_right,
	input  logic signed [DATA_W-1:0] motor_left,
	input  logic signed [DATA_W-1:0] imu_rotation,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [DATA_W-1:0] pos_x_out,
	output logic signed [DATA_W-1:0] pos_y_out,
	output logic signed [DATA_W-1:0] heading_out,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [CFG_ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready
);

	localparam int XW = FRAC_BITS + 3;

	ddo_state_t state_q, state_d;

	// configuration
	logic        use_imu_q, use_rot_q, track_en_q;
	logic [15:0] wheel_dia_q, track_q;
	logic        cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	// sample state
	logic [DATA_W-1:0] cur_rr_q, cur_rl_q, cur_mr_q, cur_ml_q, cur_im_q;
	logic [DATA_W-1:0] prev_rr_q, prev_rl_q, prev_mr_q, prev_ml_q, prev_im_q;
	logic signed [DATA_W-1:0] pose_x_q, pose_y_q, pose_h_q;
	logic have_prev_q, upd_q;

	// shared multiplier and divider
	logic [MUL_A_W-1:0] mul_a_q;
	logic [MUL_B_W-1:0] mul_b_q;
	logic [PROD_W-1:0]  acc_q, acc_nx;
	logic [DIG_W+MUL_B_W-1:0] pp;
	logic [CNT_W-1:0]   cnt_q;
	logic               mul_done, div_done;
	logic [DIV_W-1:0]   dvd_q, quo_q, quo_nx;
	logic [DREM_W-1:0]  rem_q, dsr_q, rem_nx;
	logic [DREM_W:0]    rem_sh;
	logic               div_ge;

	// intermediate results
	logic                     neg_q, s_neg_q, ang_neg_q, flip_q;
	logic signed [TRAV_W-1:0] sr_q, sl_q, ds_q;
	logic signed [DTH_W-1:0]  dth_q;
	logic signed [RED_W-1:0]  red_q;
	logic [MUL_B_W-1:0]       s_mag_q;
	logic signed [PROD_W:0]   dx_q, dy_q;

	logic signed [MAG_W-1:0] d_r, d_l, d_i;
	logic [MAG_W-1:0]        m_r, m_l, m_i;
	logic [TRAV_W-1:0]       trav_mag;
	logic signed [TRAV_W:0]  diff, ssum;
	logic [TRAV_W:0]         diff_mag, ssum_mag;
	logic [DTH_W-1:0]        dth_mag, dth_half;
	logic signed [DTH_W-1:0] ang;
	logic [DTH_W-1:0]        ang_mag;
	logic [TRAV_W-1:0]       ds_mag;
	logic [DIV_W-1:0]        mod_res;
	logic [DREM_W-1:0]       mod_r;
	logic signed [RED_W-1:0] r0, r1, r2, r3;
	logic                    fold;
	logic signed [XW-1:0]    cor_x, cor_y, c_s, s_s;
	logic [XW-1:0]           c_mag, s_mag;
	logic                    cor_start, cor_done;
	logic [PROD_W-1:0]       dxy_mag;
	logic signed [SUM_W-1:0] sum_x, sum_y, sum_h;

	// apb register port
	assign pready = 1'b1;
	assign cfg_idx = paddr[CFG_ADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (cfg_idx)
			REG_USE_IMU:   prdata = DATA_W'(use_imu_q);
			REG_USE_ROT:   prdata = DATA_W'(use_rot_q);
			REG_WHEEL_DIA: prdata = DATA_W'(wheel_dia_q);
			REG_TRACK:     prdata = DATA_W'(track_q);
			REG_TRACK_EN:  prdata = DATA_W'(track_en_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_imu_q <= 1'b0;
			use_rot_q <= 1'b0;
			wheel_dia_q <= '0;
			track_q <= '0;
			track_en_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_USE_IMU:   use_imu_q <= pwdata[0];
				REG_USE_ROT:   use_rot_q <= pwdata[0];
				REG_WHEEL_DIA: wheel_dia_q <= pwdata[15:0];
				REG_TRACK:     track_q <= pwdata[15:0];
				REG_TRACK_EN:  track_en_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// reading deltas and their magnitudes
	always_comb begin
		if (use_rot_q) begin
			d_r = $signed({cur_rr_q[DATA_W-1], cur_rr_q}) - $signed({prev_rr_q[DATA_W-1], prev_rr_q});
			d_l = $signed({cur_rl_q[DATA_W-1], cur_rl_q}) - $signed({prev_rl_q[DATA_W-1], prev_rl_q});
		end else begin
			d_r = $signed({cur_mr_q[DATA_W-1], cur_mr_q}) - $signed({prev_mr_q[DATA_W-1], prev_mr_q});
			d_l = $signed({cur_ml_q[DATA_W-1], cur_ml_q}) - $signed({prev_ml_q[DATA_W-1], prev_ml_q});
		end
		d_i = $signed({cur_im_q[DATA_W-1], cur_im_q}) - $signed({prev_im_q[DATA_W-1], prev_im_q});
		m_r = d_r[MAG_W-1] ? MAG_W'(-d_r) : MAG_W'(d_r);
		m_l = d_l[MAG_W-1] ? MAG_W'(-d_l) : MAG_W'(d_l);
		m_i = d_i[MAG_W-1] ? MAG_W'(-d_i) : MAG_W'(d_i);
	end

	// multiplier: one 16-bit digit of a per cycle
	always_comb begin
		pp = mul_a_q[DIG_W-1:0] * mul_b_q;
		acc_nx = acc_q + (PROD_W'(pp) << (DIG_W * cnt_q[1:0]));
		mul_done = (cnt_q == CNT_W'(MUL_PARTS - 1));
		trav_mag = TRAV_W'(acc_nx >> 25);
		dxy_mag = acc_nx >> FRAC_BITS;
	end

	// restoring divider: one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, dvd_q[DIV_W-1]};
		div_ge = (rem_sh >= {1'b0, dsr_q});
		rem_nx = div_ge ? DREM_W'(rem_sh - {1'b0, dsr_q}) : DREM_W'(rem_sh);
		quo_nx = {quo_q[DIV_W-2:0], div_ge};
		div_done = (cnt_q == CNT_W'(DIV_W - 1));
	end

	// travel difference and sum, midpoint angle, angle reduction, cordic sign fold, pose sums
	always_comb begin
		diff = $signed({sr_q[TRAV_W-1], sr_q}) - $signed({sl_q[TRAV_W-1], sl_q});
		diff_mag = diff[TRAV_W] ? (TRAV_W+1)'(-diff) : (TRAV_W+1)'(diff);
		ssum = $signed({sr_q[TRAV_W-1], sr_q}) + $signed({sl_q[TRAV_W-1], sl_q});
		ssum_mag = ssum[TRAV_W] ? (TRAV_W+1)'(-ssum) : (TRAV_W+1)'(ssum);
		dth_mag = dth_q[DTH_W-1] ? DTH_W'(-dth_q) : DTH_W'(dth_q);
		dth_half = dth_q[DTH_W-1] ? DTH_W'(-(dth_mag >> 1)) : (dth_mag >> 1);
		ang = $signed(DTH_W'(pose_h_q)) + $signed(dth_half);
		ang_mag = ang[DTH_W-1] ? DTH_W'(-ang) : DTH_W'(ang);
		ds_mag = ds_q[TRAV_W-1] ? TRAV_W'(-ds_q) : TRAV_W'(ds_q);
		// residual below three turns, bring it under one turn
		if (dvd_q >= DIV_W'(FOUR_PI_Q16)) begin
			mod_res = dvd_q - DIV_W'(FOUR_PI_Q16);
		end else if (dvd_q >= DIV_W'(TWO_PI_Q16)) begin
			mod_res = dvd_q - DIV_W'(TWO_PI_Q16);
		end else begin
			mod_res = dvd_q;
		end
		mod_r = DREM_W'(mod_res);
		r0 = ang_neg_q ? -$signed({1'b0, mod_r}) : $signed({1'b0, mod_r});
		r1 = (r0 < 0) ? r0 + TWO_PI_S : r0;
		r2 = (r1 > PI_Q16) ? r1 - TWO_PI_S : r1;
		fold = 1'b1;
		if (r2 > HALF_PI_Q16) begin
			r3 = r2 - PI_Q16;
		end else if (r2 < -HALF_PI_Q16) begin
			r3 = r2 + PI_Q16;
		end else begin
			r3 = r2;
			fold = 1'b0;
		end
		c_s = flip_q ? -cor_x : cor_x;
		s_s = flip_q ? -cor_y : cor_y;
		c_mag = c_s[XW-1] ? XW'(-c_s) : XW'(c_s);
		s_mag = s_s[XW-1] ? XW'(-s_s) : XW'(s_s);
		sum_x = $signed(SUM_W'(pose_x_q)) + $signed(SUM_W'(dx_q));
		sum_y = $signed(SUM_W'(pose_y_q)) + $signed(SUM_W'(dy_q));
		sum_h = $signed(SUM_W'(pose_h_q)) + $signed(SUM_W'(dth_q));
	end

	ddo_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.FRAC_BITS(FRAC_BITS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.angle(red_q),
		.done(cor_done),
		.cos_val(cor_x),
		.sin_val(cor_y)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_START;
			ST_START: state_d = (have_prev_q && track_en_q) ? ST_R1 : ST_FIN;
			ST_R1:    if (mul_done) state_d = ST_R2;
			ST_R2:    if (mul_done) state_d = ST_L1;
			ST_L1:    if (mul_done) state_d = ST_L2;
			ST_L2:    if (mul_done) state_d = ST_HDG;
			ST_HDG: begin
				if (use_imu_q) state_d = ST_IMU;
				else if (track_q == '0) state_d = ST_ANG;
				else state_d = ST_DTH;
			end
			ST_IMU:   if (mul_done) state_d = ST_ANG;
			ST_DTH:   if (div_done) state_d = ST_ANG;
			ST_ANG:   state_d = ST_MOD;
			ST_MOD:   if (mul_done) state_d = ST_MQD;
			ST_MQD:   if (mul_done) state_d = ST_MFIX;
			ST_MFIX:  state_d = ST_CGO;
			ST_CGO:   state_d = ST_COR;
			ST_COR:   if (cor_done) state_d = ST_MX;
			ST_MX:    if (mul_done) state_d = ST_MY;
			ST_MY:    if (mul_done) state_d = ST_FIN;
			ST_FIN:   state_d = ST_OUT;
			ST_OUT:   if (!out_valid || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cor_start = (state_q == ST_CGO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sample state and pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_rr_q <= '0;
			prev_rl_q <= '0;
			prev_mr_q <= '0;
			prev_ml_q <= '0;
			prev_im_q <= '0;
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_h_q <= '0;
			have_prev_q <= 1'b0;
			upd_q <= 1'b0;
		end else begin
			if (state_q == ST_START) begin
				upd_q <= have_prev_q && track_en_q;
			end
			if (state_q == ST_FIN) begin
				if (upd_q) begin
					pose_x_q <= sat32(sum_x);
					pose_y_q <= sat32(sum_y);
					pose_h_q <= sat32(sum_h);
				end
				prev_rr_q <= cur_rr_q;
				prev_rl_q <= cur_rl_q;
				prev_mr_q <= cur_mr_q;
				prev_ml_q <= cur_ml_q;
				prev_im_q <= cur_im_q;
				have_prev_q <= 1'b1;
			end
		end
	end

	// datapath registers, loaded per sequencer step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cur_rr_q <= rot_right;
					cur_rl_q <= rot_left;
					cur_mr_q <= motor_right;
					cur_ml_q <= motor_left;
					cur_im_q <= imu_rotation;
				end
			end
			ST_START: begin
				mul_a_q <= MUL_A_W'(m_r);
				mul_b_q <= DEG2RAD_Q32;
				acc_q <= '0;
				cnt_q <= '0;
				neg_q <= d_r[MAG_W-1];
			end
			ST_R1, ST_L1: begin
				if (mul_done) begin
					mul_a_q <= MUL_A_W'(acc_nx >> 16);
					mul_b_q <= MUL_B_W'(wheel_dia_q);
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					mul_a_q <= mul_a_q >> DIG_W;
					acc_q <= acc_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_R2: begin
				if (mul_done) begin
					sr_q <= neg_q ? -$signed(trav_mag) : $signed(trav_mag);
					mul_a_q <= MUL_A_W'(m_l);
					mul_b_q <= DEG2RAD_Q32;
					acc_q <= '0;
					cnt_q <= '0;
					neg_q <= d_l[MAG_W-1];
				end else begin
					mul_a_q <= mul_a_q >> DIG_W;
					acc_q <= acc_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_L2: begin
				if (mul_done) begin
					sl_q <= neg_q ? -$signed(trav_mag) : $signed(trav_mag);
				end else begin
					mul_a_q <= mul_a_q >> DIG_W;
					acc_q <= acc_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_HDG: begin
				acc_q <= '0;
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= '0;
				if (use_imu_q) begin
					mul_a_q <= MUL_A_W'(m_i);
					mul_b_q <= DEG2RAD_Q32;
					neg_q <= d_i[MAG_W-1];
				end else begin
					dvd_q <= DIV_W'({diff_mag, 8'b0});
					dsr_q <= DREM_W'(track_q);
					neg_q <= diff[TRAV_W];
				end
				if (!use_imu_q && track_q == '0) begin
					dth_q <= '0;
				end
			end
			ST_IMU: begin
				if (mul_done) begin
					dth_q <= neg_q ? -$signed(DTH_W'(acc_nx >> 32)) : $signed(DTH_W'(acc_nx >> 32));
				end else begin
					mul_a_q <= mul_a_q >> DIG_W;
					acc_q <= acc_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_DTH: begin
				dvd_q <= dvd_q << 1;
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				cnt_q <= cnt_q + 1'b1;
				if (div_done) begin
					dth_q <= neg_q ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});
				end
			end
			ST_ANG: begin
				dvd_q <= DIV_W'(ang_mag);
				mul_a_q <= MUL_A_W'(ang_mag >> RECIP_PRE);
				mul_b_q <= RECIP_TWO_PI;
				acc_q <= '0;
				cnt_q <= '0;
				ang_neg_q <= ang[DTH_W-1];
				ds_q <= ssum[TRAV_W] ? -$signed(TRAV_W'(ssum_mag >> 1))
				                     : $signed(TRAV_W'(ssum_mag >> 1));
			end
			// quotient estimate of the angle magnitude by two pi
			ST_MOD: begin
				if (mul_done) begin
					mul_a_q <= MUL_A_W'(acc_nx >> RECIP_SH);
					mul_b_q <= MUL_B_W'(TWO_PI_Q16);
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					mul_a_q <= mul_a_q >> DIG_W;
					acc_q <= acc_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			// residual after the estimated whole turns
			ST_MQD: begin
				if (mul_done) begin
					dvd_q <= dvd_q - DIV_W'(acc_nx);
				end else begin
					mul_a_q <= mul_a_q >> DIG_W;
					acc_q <= acc_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_MFIX: begin
				red_q <= r3;
				flip_q <= fold;
			end
			ST_COR: begin
				mul_a_q <= MUL_A_W'(ds_mag);
				mul_b_q <= MUL_B_W'(c_mag);
				acc_q <= '0;
				cnt_q <= '0;
				neg_q <= c_s[XW-1] ^ ds_q[TRAV_W-1];
				s_mag_q <= MUL_B_W'(s_mag);
				s_neg_q <= s_s[XW-1] ^ ds_q[TRAV_W-1];
			end
			ST_MX: begin
				if (mul_done) begin
					dx_q <= neg_q ? -$signed({1'b0, dxy_mag}) : $signed({1'b0, dxy_mag});
					mul_a_q <= MUL_A_W'(ds_mag);
					mul_b_q <= s_mag_q;
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					mul_a_q <= mul_a_q >> DIG_W;
					acc_q <= acc_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_MY: begin
				if (mul_done) begin
					dy_q <= s_neg_q ? -$signed({1'b0, dxy_mag}) : $signed({1'b0, dxy_mag});
				end else begin
					mul_a_q <= mul_a_q >> DIG_W;
					acc_q <= acc_nx;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// output register, holds a result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			pos_x_out <= pose_x_q;
			pos_y_out <= pose_y_q;
			heading_out <= pose_h_q;
		end
	end

endmodule

[rtl/ddo_cordic.sv]
module ddo_cordic import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [RED_W-1:0]     angle,
	output logic                        done,
	output logic signed [FRAC_BITS+2:0] cos_val,
	output logic signed [FRAC_BITS+2:0] sin_val
);

	localparam int XW = FRAC_BITS + 3;
	localparam int ZW = FRAC_BITS + 4;
	localparam int IW = $clog2(CORDIC_STEPS);
	localparam int UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int DN = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
	localparam int TS = 30 - FRAC_BITS;
	localparam int ZMW = RED_W + 8;

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [IW-1:0]        i_q;
	logic                 busy_q, done_q;

	logic [RED_W-1:0]     a_mag;
	logic [ZMW-1:0]       z_mag_w;
	logic [ZW-1:0]        z_mag;
	logic signed [ZW-1:0] z0;
	logic signed [XW-1:0] x0;
	logic [XW-1:0]        x_mag, y_mag, xs_mag, ys_mag;
	logic signed [XW-1:0] xs, ys;
	logic signed [ZW-1:0] t;
	logic                 last;

	// start angle scaled to the working fraction, truncating toward zero
	always_comb begin
		a_mag = angle[RED_W-1] ? RED_W'(-angle) : RED_W'(angle);
		z_mag_w = (ZMW'(a_mag) << UP) >> DN;
		z_mag = ZW'(z_mag_w);
		z0 = angle[RED_W-1] ? -$signed(z_mag) : $signed(z_mag);
		x0 = $signed(XW'(GAIN_Q30 >> TS));
	end

	// one micro-rotation per cycle
	always_comb begin
		x_mag = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
		y_mag = y_q[XW-1] ? XW'(-y_q) : XW'(y_q);
		xs_mag = x_mag >> i_q;
		ys_mag = y_mag >> i_q;
		xs = x_q[XW-1] ? -$signed(xs_mag) : $signed(xs_mag);
		ys = y_q[XW-1] ? -$signed(ys_mag) : $signed(ys_mag);
		t = $signed(ZW'(atan_q30(5'(i_q)) >> TS));
		last = (i_q == IW'(CORDIC_STEPS - 1));
	end

	// iteration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				x_q <= x0;
				y_q <= '0;
				z_q <= z0;
			end else if (busy_q) begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - t;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + t;
				end
				if (last) begin
					busy_q <= 1'b0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign cos_val = x_q;
	assign sin_val = y_q;

endmodule

[rtl/ddo_checker.sv]
module ddo_checker import ddo_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [DATA_W-1:0] pos_x_out,
	input logic signed [DATA_W-1:0] pos_y_out,
	input logic signed [DATA_W-1:0] heading_out,
	input logic                    pready
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x_out)
			&& $stable(pos_y_out) && $stable(heading_out))
		else $error("stalled result changed");

	// one item at a time: busy after an input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a new result only appears at the end of a busy spell
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without work");

	// apb port never waits
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);
